// ----- rtl/arm_pkg.sv -----
package arm_pkg;

  localparam int ADDR_BITS = 52;
  localparam int MAX_REGIONS_DEF = 64;

  typedef enum logic [1:0] {
    FN_CONVERT,
    FN_QUERY,
    FN_READ,
    FN_RSVD
  } func_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_OVERLAP,
    ST_FULL,
    ST_BAD_RANGE
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SCAN,
    S_DECIDE,
    S_GAP,
    S_PUT,
    S_ML_RD,
    S_ML_EV,
    S_MR_RD,
    S_MR_EV,
    S_MW,
    S_DROP,
    S_ENT_RD,
    S_ENT_EV,
    S_FIN
  } fsm_t;

  typedef struct packed {
    func_t       func;
    logic [3:0]  region_type;
    logic [51:0] base_addr;
    logic [52:0] range_length;
    logic [5:0]  entry_index;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  found_type;
    logic [51:0] entry_start;
    logic [52:0] entry_length;
    logic [6:0]  region_count;
  } result_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] first;
    logic [ADDR_BITS-1:0] last;
    logic [3:0]           kind;
  } region_t;

endpackage

// ----- rtl/address_region_map_core.sv -----
// A bad range or reserved func goes from check to finish; read-entry reads the
// addressed entry; query scans the table one region a cycle; convert scans and
// finishes on overlap, a full table or no type change, else runs a shift-up
// pass, up to three piece writes, two neighbor reads and a shift-down pass. One
// beat at a time; start is taken again after done. done strobes the result for
// one cycle; the receiver cannot stall it. Synchronous reset empties the table.
module address_region_map_core #(
  parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  arm_pkg::request_t request,
  output logic              done,
  output arm_pkg::result_t  result
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AB = arm_pkg::ADDR_BITS;
  localparam int RW = $bits(arm_pkg::region_t);

  arm_pkg::fsm_t    state, state_next;
  arm_pkg::request_t req;
  arm_pkg::region_t rd, hreg;
  arm_pkg::region_t piece [3];
  arm_pkg::status_t status_q;

  logic [AB-1:0] lastq, ms, me;
  logic [CW-1:0] cnt, k, hidx, pos, gap_from, pa, c, lidx, ridx;
  logic [AW-1:0] wa;
  logic [1:0]    gap_n, np, pc;
  logic          pv, hit, ovl;
  logic [3:0]    ftype_q;
  logic [51:0]   estart_q;
  logic [52:0]   elen_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  logic [53:0]   last_w;
  logic          bad;
  logic          e_in, e_past, scan_stop, scan_end;
  logic          lo, hi, full1, full2;
  logic          mrg_l, mrg_r;
  logic          gap_done, drop_done;
  logic [CW-1:0] dd;
  logic [AB-1:0] base;
  logic [3:0]    t;

  arm_ram #(.WIDTH(RW), .DEPTH(MAX_REGIONS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd     = arm_pkg::region_t'(ram_rdata);
  assign base   = req.base_addr;
  assign t      = req.region_type;
  assign last_w = {2'b00, req.base_addr} + {1'b0, req.range_length} - 54'd1;
  assign bad    = (req.range_length == '0) || (last_w > {2'b00, {AB{1'b1}}});

  assign e_in      = (rd.first <= base) && (base <= rd.last);
  assign e_past    = rd.first > base;
  assign scan_stop = pv && (e_in || e_past);
  assign scan_end  = !pv && (k >= cnt);

  assign lo    = hreg.first < base;
  assign hi    = hreg.last > lastq;
  assign full1 = {1'b0, cnt} + (CW+1)'(1) > (CW+1)'(MAX_REGIONS);
  assign full2 = {1'b0, cnt} + (CW+1)'(lo) + (CW+1)'(hi) > (CW+1)'(MAX_REGIONS);

  assign mrg_l = (rd.kind == t) && ({1'b0, rd.last} + 1'b1 == {1'b0, base});
  assign mrg_r = (rd.kind == t) && ({1'b0, lastq} + 1'b1 == {1'b0, rd.first});

  assign gap_done  = !pv && (k <= gap_from);
  assign drop_done = !pv && (k >= cnt);
  assign dd        = ridx - lidx;

  always_comb begin
    state_next = state;
    unique case (state)
      arm_pkg::S_IDLE: if (start) state_next = arm_pkg::S_CHK;
      arm_pkg::S_CHK: begin
        unique case (req.func)
          arm_pkg::FN_CONVERT,
          arm_pkg::FN_QUERY: state_next = bad ? arm_pkg::S_FIN : arm_pkg::S_SCAN;
          arm_pkg::FN_READ:  state_next = arm_pkg::S_ENT_RD;
          default:           state_next = arm_pkg::S_FIN;
        endcase
      end
      arm_pkg::S_SCAN: begin
        if (scan_stop || scan_end) begin
          state_next = (req.func == arm_pkg::FN_QUERY) ? arm_pkg::S_FIN : arm_pkg::S_DECIDE;
        end
      end
      arm_pkg::S_DECIDE: begin
        if (!hit) begin
          state_next = (ovl || full1) ? arm_pkg::S_FIN : arm_pkg::S_GAP;
        end else if (hreg.last < lastq || hreg.kind == t || full2) begin
          state_next = arm_pkg::S_FIN;
        end else begin
          state_next = arm_pkg::S_GAP;
        end
      end
      arm_pkg::S_GAP:    if (gap_done) state_next = arm_pkg::S_PUT;
      arm_pkg::S_PUT:    if (pc == np - 2'd1) state_next = arm_pkg::S_ML_RD;
      arm_pkg::S_ML_RD:  state_next = (c == '0) ? arm_pkg::S_MR_RD : arm_pkg::S_ML_EV;
      arm_pkg::S_ML_EV:  state_next = arm_pkg::S_MR_RD;
      arm_pkg::S_MR_RD:  state_next = (c + 1'b1 < cnt) ? arm_pkg::S_MR_EV : arm_pkg::S_MW;
      arm_pkg::S_MR_EV:  state_next = arm_pkg::S_MW;
      arm_pkg::S_MW:     state_next = arm_pkg::S_DROP;
      arm_pkg::S_DROP:   if (drop_done) state_next = arm_pkg::S_FIN;
      arm_pkg::S_ENT_RD: begin
        state_next = (int'(req.entry_index) < int'(cnt)) ? arm_pkg::S_ENT_EV : arm_pkg::S_FIN;
      end
      arm_pkg::S_ENT_EV: state_next = arm_pkg::S_FIN;
      arm_pkg::S_FIN:    state_next = arm_pkg::S_IDLE;
      default:           state_next = arm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic [CW-1:0] tmp;
    tmp       = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state)
      arm_pkg::S_SCAN: ram_raddr = k[AW-1:0];
      arm_pkg::S_GAP: begin
        tmp       = k - 1'b1;
        ram_raddr = tmp[AW-1:0];
        ram_we    = pv;
        ram_waddr = wa;
        ram_wdata = ram_rdata;
      end
      arm_pkg::S_PUT: begin
        tmp       = pa + CW'(pc);
        ram_we    = 1'b1;
        ram_waddr = tmp[AW-1:0];
        ram_wdata = piece[pc];
      end
      arm_pkg::S_ML_RD: begin
        tmp       = c - 1'b1;
        ram_raddr = tmp[AW-1:0];
      end
      arm_pkg::S_MR_RD: begin
        tmp       = c + 1'b1;
        ram_raddr = tmp[AW-1:0];
      end
      arm_pkg::S_MW: begin
        ram_we    = 1'b1;
        ram_waddr = lidx[AW-1:0];
        ram_wdata = {ms, me, t};
      end
      arm_pkg::S_DROP: begin
        ram_raddr = k[AW-1:0];
        ram_we    = pv;
        ram_waddr = wa;
        ram_wdata = ram_rdata;
      end
      arm_pkg::S_ENT_RD: ram_raddr = AW'(req.entry_index);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arm_pkg::S_IDLE;
      cnt   <= '0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        arm_pkg::S_IDLE: begin
          if (start) begin
            req      <= request;
            status_q <= arm_pkg::ST_OK;
            ftype_q  <= '0;
            estart_q <= '0;
            elen_q   <= '0;
          end
        end
        arm_pkg::S_CHK: begin
          lastq <= last_w[AB-1:0];
          k     <= '0;
          pv    <= 1'b0;
          if (req.func == arm_pkg::FN_RSVD ||
              (req.func != arm_pkg::FN_READ && bad)) begin
            status_q <= arm_pkg::ST_BAD_RANGE;
          end
        end
        arm_pkg::S_SCAN: begin
          if (scan_stop) begin
            hit  <= e_in;
            hidx <= k - 1'b1;
            hreg <= rd;
            pos  <= k - 1'b1;
            ovl  <= e_past && (rd.first <= lastq);
            if (req.func == arm_pkg::FN_QUERY) begin
              if (e_in && lastq <= rd.last) begin
                ftype_q <= rd.kind;
              end else begin
                status_q <= arm_pkg::ST_NOT_FOUND;
              end
            end
          end else if (scan_end) begin
            hit <= 1'b0;
            pos <= cnt;
            ovl <= 1'b0;
            if (req.func == arm_pkg::FN_QUERY) status_q <= arm_pkg::ST_NOT_FOUND;
          end else begin
            if (k < cnt) k <= k + 1'b1;
            pv <= k < cnt;
          end
        end
        arm_pkg::S_DECIDE: begin
          pv <= 1'b0;
          pc <= '0;
          if (!hit) begin
            if (ovl) status_q <= arm_pkg::ST_OVERLAP;
            else if (full1) status_q <= arm_pkg::ST_FULL;
            gap_from <= pos;
            gap_n    <= 2'd1;
            k        <= cnt;
            pa       <= pos;
            c        <= pos;
            np       <= 2'd1;
            piece[0] <= {base, lastq, t};
          end else begin
            if (hreg.last < lastq) status_q <= arm_pkg::ST_OVERLAP;
            else if (hreg.kind != t && full2) status_q <= arm_pkg::ST_FULL;
            gap_from <= hidx + 1'b1;
            gap_n    <= {1'b0, lo} + {1'b0, hi};
            k        <= cnt;
            pa       <= hidx;
            c        <= hidx + CW'(lo);
            np       <= 2'd1 + {1'b0, lo} + {1'b0, hi};
            piece[0] <= lo ? {hreg.first, base - 1'b1, hreg.kind} : {base, lastq, t};
            piece[1] <= lo ? {base, lastq, t} : {lastq + 1'b1, hreg.last, hreg.kind};
            piece[2] <= {lastq + 1'b1, hreg.last, hreg.kind};
          end
        end
        arm_pkg::S_GAP: begin
          if (k > gap_from) begin
            pv <= 1'b1;
            wa <= AW'(k - 1'b1 + CW'(gap_n));
            k  <= k - 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (gap_done) cnt <= cnt + CW'(gap_n);
        end
        arm_pkg::S_PUT: pc <= pc + 2'd1;
        arm_pkg::S_ML_RD: begin
          ms   <= base;
          lidx <= c;
        end
        arm_pkg::S_ML_EV: begin
          if (mrg_l) begin
            ms   <= rd.first;
            lidx <= c - 1'b1;
          end
        end
        arm_pkg::S_MR_RD: begin
          me   <= lastq;
          ridx <= c;
        end
        arm_pkg::S_MR_EV: begin
          if (mrg_r) begin
            me   <= rd.last;
            ridx <= c + 1'b1;
          end
        end
        arm_pkg::S_MW: begin
          k  <= ridx + 1'b1;
          pv <= 1'b0;
        end
        arm_pkg::S_DROP: begin
          if (k < cnt) begin
            pv <= 1'b1;
            wa <= AW'(k - dd);
            k  <= k + 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (drop_done) cnt <= cnt - dd;
        end
        arm_pkg::S_ENT_RD: begin
          if (!(int'(req.entry_index) < int'(cnt))) status_q <= arm_pkg::ST_NOT_FOUND;
        end
        arm_pkg::S_ENT_EV: begin
          ftype_q  <= rd.kind;
          estart_q <= 52'(rd.first);
          elen_q   <= 53'({1'b0, rd.last} - {1'b0, rd.first} + 1'b1);
        end
        default: ;
      endcase
    end
  end

  assign busy                = state != arm_pkg::S_IDLE;
  assign done                = state == arm_pkg::S_FIN;
  assign result.status       = status_q;
  assign result.found_type   = ftype_q;
  assign result.entry_start  = estart_q;
  assign result.entry_length = elen_q;
  assign result.region_count = 7'(cnt);

endmodule

// ----- rtl/arm_ram.sv -----
module arm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/arm_check.sv -----
module arm_check #(
  parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input arm_pkg::result_t  result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy");

  a_accept: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("beat accepted but not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> int'(result.region_count) <= MAX_REGIONS)
    else $error("region count above capacity");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    done && result.status == arm_pkg::ST_BAD_RANGE |->
      result.found_type == '0 && result.entry_length == '0)
    else $error("bad range beat carries data");

endmodule

bind address_region_map_core arm_check #(.MAX_REGIONS(MAX_REGIONS)) u_chk (.*);

// ----- verif/tb.sv -----
module tb;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  arm_pkg::request_t request;
  logic              done;
  arm_pkg::result_t  result;

  address_region_map_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  localparam int NREG = 64;
  localparam logic [51:0] AMAX = '1;

  // shadow region table
  logic [51:0] tab_first [NREG];
  logic [51:0] tab_last  [NREG];
  logic [3:0]  tab_kind  [NREG];
  int          tab_count;

  arm_pkg::result_t want_q[$];
  int               errors;
  bit               idle_ok;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic int find_holder(logic [51:0] a);
    for (int i = 0; i < tab_count; i++)
      if (tab_first[i] <= a && a <= tab_last[i]) return i;
    return -1;
  endfunction

  function automatic bit range_bad(logic [51:0] b, logic [52:0] len);
    logic [52:0] room;
    room = {1'b0, AMAX} - {1'b0, b};
    return len == 53'd0 || (len - 53'd1) > room;
  endfunction

  function automatic void shift_up(int pos, int n);
    for (int k = tab_count - 1; k >= pos; k--) begin
      tab_first[k+n] = tab_first[k];
      tab_last[k+n]  = tab_last[k];
      tab_kind[k+n]  = tab_kind[k];
    end
    tab_count += n;
  endfunction

  function automatic void remove_at(int pos);
    for (int k = pos; k + 1 < tab_count; k++) begin
      tab_first[k] = tab_first[k+1];
      tab_last[k]  = tab_last[k+1];
      tab_kind[k]  = tab_kind[k+1];
    end
    tab_count--;
  endfunction

  function automatic void put(int p, logic [51:0] f, logic [51:0] l, logic [3:0] t);
    tab_first[p] = f; tab_last[p] = l; tab_kind[p] = t;
  endfunction

  function automatic arm_pkg::status_t retype(logic [3:0] t, logic [51:0] b,
                                              logic [51:0] e);
    int i, c, pos, lo, hi;
    logic [51:0] os, oe;
    logic [3:0] ot;
    i = find_holder(b);
    if (i < 0) begin
      pos = 0;
      while (pos < tab_count && tab_first[pos] < b) pos++;
      if (pos < tab_count && tab_first[pos] <= e) return arm_pkg::ST_OVERLAP;
      if (tab_count + 1 > NREG) return arm_pkg::ST_FULL;
      shift_up(pos, 1);
      put(pos, b, e, t);
      c = pos;
    end else begin
      os = tab_first[i]; oe = tab_last[i]; ot = tab_kind[i];
      if (oe < e) return arm_pkg::ST_OVERLAP;
      if (ot == t) return arm_pkg::ST_OK;
      lo = (os < b) ? 1 : 0;
      hi = (oe > e) ? 1 : 0;
      if (tab_count + lo + hi > NREG) return arm_pkg::ST_FULL;
      shift_up(i + 1, lo + hi);
      c = i;
      if (lo != 0) begin
        put(c, os, b - 52'd1, ot);
        c++;
      end
      put(c, b, e, t);
      if (hi != 0) put(c + 1, e + 52'd1, oe, ot);
    end
    if (c > 0 && tab_kind[c-1] == tab_kind[c] && tab_last[c-1] + 52'd1 == tab_first[c]
        && tab_last[c-1] != AMAX) begin
      tab_last[c-1] = tab_last[c];
      remove_at(c);
      c--;
    end
    if (c + 1 < tab_count && tab_kind[c] == tab_kind[c+1]
        && tab_last[c] + 52'd1 == tab_first[c+1] && tab_last[c] != AMAX) begin
      tab_last[c] = tab_last[c+1];
      remove_at(c + 1);
    end
    return arm_pkg::ST_OK;
  endfunction

  function automatic arm_pkg::result_t map_step(arm_pkg::request_t rq);
    arm_pkg::result_t r;
    int i;
    logic [51:0] e;
    r = '0;
    r.status = arm_pkg::ST_OK;
    e = rq.base_addr + rq.range_length[51:0] - 52'd1;
    case (rq.func)
      arm_pkg::FN_CONVERT: begin
        if (range_bad(rq.base_addr, rq.range_length)) r.status = arm_pkg::ST_BAD_RANGE;
        else r.status = retype(rq.region_type, rq.base_addr, e);
      end
      arm_pkg::FN_QUERY: begin
        if (range_bad(rq.base_addr, rq.range_length)) r.status = arm_pkg::ST_BAD_RANGE;
        else begin
          i = find_holder(rq.base_addr);
          if (i < 0 || e > tab_last[i]) r.status = arm_pkg::ST_NOT_FOUND;
          else r.found_type = tab_kind[i];
        end
      end
      arm_pkg::FN_READ: begin
        if (int'(rq.entry_index) < tab_count) begin
          r.found_type   = tab_kind[rq.entry_index];
          r.entry_start  = tab_first[rq.entry_index];
          r.entry_length = {1'b0, tab_last[rq.entry_index]}
                           - {1'b0, tab_first[rq.entry_index]} + 53'd1;
        end else r.status = arm_pkg::ST_NOT_FOUND;
      end
      default: r.status = arm_pkg::ST_BAD_RANGE;
    endcase
    r.region_count = tab_count[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    arm_pkg::result_t w;
    if (!rst && done) begin
      if (want_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        w = want_q.pop_front();
        if (result.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, result.status); errors++;
        end
        if (result.found_type !== w.found_type) begin
          $error("found_type exp %0d got %0d", w.found_type, result.found_type); errors++;
        end
        if (result.entry_start !== w.entry_start) begin
          $error("entry_start exp %0h got %0h", w.entry_start, result.entry_start); errors++;
        end
        if (result.entry_length !== w.entry_length) begin
          $error("entry_length exp %0h got %0h", w.entry_length, result.entry_length);
          errors++;
        end
        if (result.region_count !== w.region_count) begin
          $error("region_count exp %0d got %0d", w.region_count, result.region_count);
          errors++;
        end
      end
    end
  end

  task automatic send(arm_pkg::func_t f, logic [3:0] t, logic [51:0] b,
                      logic [52:0] len, logic [5:0] idx);
    arm_pkg::request_t rq;
    int gap;
    rq.func = f; rq.region_type = t; rq.base_addr = b;
    rq.range_length = len; rq.entry_index = idx;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    want_q.push_back(map_step(rq));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all();
    for (int i = 0; i < 64; i++) send(arm_pkg::FN_READ, 4'h0, 52'h0, 53'h0, 6'(i));
  endtask

  task automatic test_directed();
    send(arm_pkg::FN_READ, 4'h0, 52'h0, 53'h0, 6'd0);
    send(arm_pkg::FN_QUERY, 4'h0, 52'h10, 53'h1, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h1, 52'h10, 53'h0, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h1, AMAX, 53'h2, 6'd0);
    send(arm_pkg::FN_QUERY, 4'h1, AMAX, 53'h0, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'hf, AMAX, 53'h1, 6'd63);
    send(arm_pkg::FN_CONVERT, 4'h1, 52'h0, {1'b1, 52'h0}, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h3, 52'h0, 53'h100, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h3, 52'h10, 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h5, 52'h40, 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h5, 52'h0, 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h3, 52'h40, 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h7, 52'hf0, 53'h20, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h7, 52'h200, 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h7, 52'h1f8, 53'h10, 6'd0);
    send(arm_pkg::FN_QUERY, 4'h0, 52'h20, 53'he0, 6'd0);
    send(arm_pkg::FN_QUERY, 4'h0, 52'h20, 53'he1, 6'd0);
    send(arm_pkg::FN_QUERY, 4'h0, 52'h180, 53'h1, 6'd0);
    send(arm_pkg::FN_RSVD, 4'ha, 52'h5, 53'h5, 6'd5);
    send(arm_pkg::FN_READ, 4'h0, 52'h0, 53'h0, 6'd1);
    send(arm_pkg::FN_READ, 4'h0, 52'h0, 53'h0, 6'd63);
  endtask

  task automatic test_fill();
    for (int i = 0; i < 70; i++)
      send(arm_pkg::FN_CONVERT, 4'(i), 52'h100000 + 52'(i * 32), 53'h10, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h9, 52'h100000, 53'h4, 6'd0);
    send(arm_pkg::FN_CONVERT, 4'h9, 52'h100004, 53'h4, 6'd0);
    read_all();
  endtask

  task automatic test_random(int n);
    logic [51:0] b;
    logic [52:0] len;
    int i, p;
    arm_pkg::func_t f;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 60) f = arm_pkg::FN_CONVERT;
      else if (p < 80) f = arm_pkg::FN_QUERY;
      else if (p < 97) f = arm_pkg::FN_READ;
      else f = arm_pkg::FN_RSVD;
      if ($urandom_range(0, 9) < 7 && tab_count > 0) begin
        i = $urandom_range(0, tab_count - 1);
        b = tab_first[i] + 52'($urandom_range(0, 3));
        len = 53'($urandom_range(0, 40));
      end else if ($urandom_range(0, 9) == 0) begin
        b = 52'({$urandom, $urandom});
        len = 53'({$urandom, $urandom});
        if ($urandom_range(0, 1) == 1) len = {1'b0, AMAX - b} + 53'($urandom_range(0, 2));
      end else begin
        b = 52'($urandom_range(0, 4095));
        len = 53'($urandom_range(1, 64));
      end
      send(f, 4'($urandom_range(0, 3)), b, len, 6'($urandom_range(0, tab_count + 2)));
    end
  endtask

  initial begin
    errors = 0;
    idle_ok = 1'b1;
    tab_count = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill();
    test_random(700);
    idle_ok = 1'b0;
    test_random(100);
    while (want_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
